>>> sv/rrp_pkg.sv
package rrp_pkg;

    // Ring geometry (ring size is a power of two; slot = serial & mask).
    localparam int RING_VERTICES   = 131072;
    localparam int WINDOW_VERTICES = 65536;
    localparam int TABLE_ENTRIES   = 4096;

    localparam int SERIAL_W = 32;
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);

    // Field widths
    localparam int TYPE_W   = 2;
    localparam int INDEX_W  = 16;
    localparam int SPAN_W   = 17;
    localparam int DRAW_W   = 16;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 17;
    localparam int THR_W    = 16;

    localparam logic [SERIAL_W-1:0] RING_SERIAL   = SERIAL_W'(RING_VERTICES);
    localparam logic [SERIAL_W-1:0] RING_MASK     = SERIAL_W'(RING_VERTICES - 1);
    localparam logic [SERIAL_W-1:0] WINDOW_SERIAL = SERIAL_W'(WINDOW_VERTICES);
    localparam logic [SERIAL_W-1:0] TABLE_SERIAL  = SERIAL_W'(TABLE_ENTRIES);
    localparam logic [SERIAL_W-1:0] SERIAL_NONE   = '1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(64);

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_PLACE       = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FRAME_START = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_FRAME_END   = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_CLEAR       = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEWLAP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVENT  = 3'd4;

    // Control from the sequencer to the serial table
    typedef struct packed {
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
        logic                wr_en;
        logic [IDX_W-1:0]    wr_addr;
        logic [SERIAL_W-1:0] wr_data;
        logic                clr_start;
    } t_tbl_req;

    function automatic logic [ADDR_W-1:0] ring_slot(input logic [SERIAL_W-1:0] serial);
        logic [SERIAL_W-1:0] masked;
        masked = serial & RING_MASK;
        return masked[ADDR_W-1:0];
    endfunction

endpackage

>>> sv/rrp_table.sv
module rrp_table
    import rrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tbl_req            i_req,
    output logic [SERIAL_W-1:0] o_rd_data,
    output logic                o_busy
);

    logic [SERIAL_W-1:0] r_mem [TABLE_ENTRIES];
    logic [SERIAL_W-1:0] r_rd_data;
    logic [IDX_W-1:0]    r_clr_addr;
    logic                r_busy;

    // Clear sweep: one entry per cycle, starts after reset and on request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_req.clr_start) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

>>> sv/resident_ring_placement_core.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------
// request   | in        | i_in_valid / o_in_ready    | i_req_type, i_entry_index, i_span,
//           |           |                            | i_draw_items
// result    | out       | o_out_valid / i_out_ready  | o_status, o_ring_address, o_compacted
// config    | in        | i_cfg_we (no wait)         | i_cfg_wdata
//
// Place, frame start and frame end: the accept cycle issues the serial-table
// read, and the lookup state then compares and writes back once the output register is free.
// Clear table walks the 4096-entry table one entry per cycle.
// Reset (i_rst_n low, synchronous) runs the same sweep; no request
// is taken until it ends. A stalled result holds in the output register; the
// lookup waits there until the register frees.
module resident_ring_placement_core
    import rrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_we,
    input  logic [THR_W-1:0]    i_cfg_wdata,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [TYPE_W-1:0]   i_req_type,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic [SPAN_W-1:0]   i_span,
    input  logic [DRAW_W-1:0]   i_draw_items,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ADDR_W-1:0]   o_ring_address,
    output logic                o_compacted
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [THR_W-1:0]    r_thr;
    logic [SERIAL_W-1:0] r_head, n_head;
    logic [SERIAL_W-1:0] r_oldest, n_oldest;

    // Request latched at accept, with placement math done up front
    logic [TYPE_W-1:0]   r_req_type;
    logic [INDEX_W-1:0]  r_idx;
    logic [SPAN_W-1:0]   r_span;
    logic                r_comp;
    logic                r_wraps;
    logic [SERIAL_W-1:0] r_place_end;
    logic [SERIAL_W-1:0] r_place_base;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_compacted, n_compacted;

    t_tbl_req            tbl_req;
    logic [SERIAL_W-1:0] tbl_rdata;
    logic                tbl_busy;

    logic                in_acc;
    logic                out_free;

    // Accept-cycle placement math (head is stable while idle)
    logic [SERIAL_W-1:0] cur_slot;
    logic [SERIAL_W-1:0] span32;
    logic [SERIAL_W:0]   slot_end;
    logic                acc_wraps;
    logic                acc_comp;
    logic [SERIAL_W-1:0] lap_base;
    logic [SERIAL_W-1:0] acc_place_end;
    logic [SERIAL_W-1:0] acc_place_base;

    // Lookup-cycle checks
    logic                bad_req;
    logic [SERIAL_W-1:0] hit_age;
    logic                hit;
    logic [SERIAL_W-1:0] guard_age;
    logic                guard;
    logic [SERIAL_W-1:0] look_span32;

    rrp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rdata),
        .o_busy    (tbl_busy)
    );

    assign o_in_ready = (r_state == S_IDLE) && !tbl_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        cur_slot  = r_head & RING_MASK;
        span32    = SERIAL_W'(i_span);
        slot_end  = {1'b0, cur_slot} + {1'b0, span32};
        acc_wraps = slot_end > {1'b0, RING_SERIAL};
        acc_comp  = i_draw_items > r_thr;
        // start of the next lap = head - slot + ring
        lap_base  = (r_head & ~RING_MASK) + RING_SERIAL;
        acc_place_end = acc_wraps ? (lap_base + span32) : (r_head + span32);
        // compaction (before the lap skip) leaves the slot unchanged: it only
        // pushes the new-lap base one ring further
        if (acc_wraps) begin
            acc_place_base = acc_comp ? (lap_base + RING_SERIAL) : lap_base;
        end else begin
            acc_place_base = r_head;
        end
    end

    always_comb begin
        look_span32 = SERIAL_W'(r_span);
        bad_req     = (r_span == '0) || (look_span32 > WINDOW_SERIAL) ||
                      (SERIAL_W'(r_idx) >= TABLE_SERIAL);
        hit_age     = r_head - tbl_rdata;
        hit         = (tbl_rdata != '0) && (hit_age <= RING_SERIAL);
        guard_age   = r_place_end - r_oldest;
        guard       = (r_oldest != SERIAL_NONE) && (guard_age > RING_SERIAL);
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_oldest    = r_oldest;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_addr      = r_addr;
        n_compacted = r_compacted;

        tbl_req           = '0;
        tbl_req.rd_addr   = i_entry_index[IDX_W-1:0];
        tbl_req.wr_addr   = r_idx[IDX_W-1:0];
        tbl_req.wr_data   = r_place_base;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_CLEAR) begin
                        tbl_req.clr_start = 1'b1;
                        n_state           = S_CLEAR;
                    end else begin
                        tbl_req.rd_en = 1'b1;
                        n_state       = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_EVENT;
                    n_addr      = '0;
                    n_compacted = 1'b0;
                    case (r_req_type)
                        REQ_FRAME_START: begin
                            n_oldest = SERIAL_NONE;
                        end
                        REQ_FRAME_END: begin
                            n_compacted = r_comp;
                            if (r_comp) begin
                                n_head = r_head + RING_SERIAL;
                            end
                        end
                        REQ_PLACE: begin
                            if (bad_req) begin
                                n_status = ST_REJECT;
                            end else if (hit) begin
                                n_status = ST_HIT;
                                n_addr   = ring_slot(tbl_rdata);
                                if (tbl_rdata < r_oldest) begin
                                    n_oldest = tbl_rdata;
                                end
                            end else if (guard) begin
                                n_status = ST_REJECT;
                            end else begin
                                // write back the new serial, advance the head
                                tbl_req.wr_en = 1'b1;
                                n_head        = r_place_base + look_span32;
                                if (r_place_base < r_oldest) begin
                                    n_oldest = r_place_base;
                                end
                                if (r_wraps) begin
                                    n_status    = ST_NEWLAP;
                                    n_addr      = '0;
                                    n_compacted = r_comp;
                                end else begin
                                    n_status = ST_PLACED;
                                    n_addr   = ring_slot(r_place_base);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                if (!tbl_busy && out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_EVENT;
                    n_addr      = '0;
                    n_compacted = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_head      <= RING_SERIAL;
            r_oldest    <= SERIAL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_oldest    <= n_oldest;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_addr      <= n_addr;
        r_compacted <= n_compacted;
        if (in_acc) begin
            r_req_type   <= i_req_type;
            r_idx        <= i_entry_index;
            r_span       <= i_span;
            r_comp       <= acc_comp;
            r_wraps      <= acc_wraps;
            r_place_end  <= acc_place_end;
            r_place_base <= acc_place_base;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_ring_address = r_addr;
    assign o_compacted    = r_compacted;

endmodule

>>> verif/tb_resident_ring_placement_core.sv
`timescale 1ns / 1ps

import rrp_pkg::*;

typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   ring_address;
    logic                compacted;
} t_placement_result;

// Scoreboard with its own copy of the ring state
class placement_scoreboard;
    bit [SERIAL_W-1:0] head_serial;
    bit [SERIAL_W-1:0] oldest_serial;
    bit [SERIAL_W-1:0] serial_tbl [TABLE_ENTRIES];
    bit [THR_W-1:0]    draw_threshold;
    t_placement_result placements_due[$];
    int                fails;
    int                tally [5];
    int                compactions;

    function new();
        head_serial    = RING_SERIAL;
        oldest_serial  = SERIAL_NONE;
        draw_threshold = THR_RESET;
        foreach (serial_tbl[i]) serial_tbl[i] = '0;
    endfunction

    function void set_threshold(bit [THR_W-1:0] value);
        draw_threshold = value;
    endfunction

    function int outstanding();
        return placements_due.size();
    endfunction

    // Frame-end style check: empty the ring by skipping a full lap
    function bit compact_ring(bit [DRAW_W-1:0] draws);
        if (draws > draw_threshold) begin
            head_serial += RING_SERIAL;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void take_request(logic [TYPE_W-1:0] req, logic [INDEX_W-1:0] idx,
                               logic [SPAN_W-1:0] span, logic [DRAW_W-1:0] draws);
        t_placement_result exp;
        bit [SERIAL_W-1:0] span32;
        bit [SERIAL_W-1:0] serial;
        bit [SERIAL_W-1:0] slot;
        bit [SERIAL_W-1:0] place_end;
        bit                wraps;
        exp.status       = ST_EVENT;
        exp.ring_address = '0;
        exp.compacted    = 1'b0;
        span32 = SERIAL_W'(span);
        if (req == REQ_FRAME_START) begin
            oldest_serial = SERIAL_NONE;
        end else if (req == REQ_FRAME_END) begin
            exp.compacted = compact_ring(draws);
        end else if (req == REQ_CLEAR) begin
            foreach (serial_tbl[i]) serial_tbl[i] = '0;
        end else if (span32 == 0 || span32 > WINDOW_SERIAL ||
                     SERIAL_W'(idx) >= TABLE_SERIAL) begin
            exp.status = ST_REJECT;
        end else begin
            serial = serial_tbl[idx[IDX_W-1:0]];
            if (serial != 0 && (head_serial - serial) <= RING_SERIAL) begin
                // still resident: within one lap of the head
                if (serial < oldest_serial) oldest_serial = serial;
                exp.status = ST_HIT;
                slot = serial % RING_SERIAL;
                exp.ring_address = slot[ADDR_W-1:0];
            end else begin
                slot  = head_serial % RING_SERIAL;
                wraps = (slot + span32) > RING_SERIAL;
                place_end = head_serial + span32;
                if (wraps) place_end = head_serial + (RING_SERIAL - slot) + span32;
                if (oldest_serial != SERIAL_NONE &&
                    (place_end - oldest_serial) > RING_SERIAL) begin
                    exp.status = ST_REJECT;    // would overwrite live data
                end else begin
                    exp.status = ST_PLACED;
                    if (wraps) begin
                        exp.compacted = compact_ring(draws);
                        head_serial += RING_SERIAL - slot;
                        slot = '0;
                        exp.status = ST_NEWLAP;
                    end
                    serial_tbl[idx[IDX_W-1:0]] = head_serial;
                    if (head_serial < oldest_serial) oldest_serial = head_serial;
                    head_serial += span32;
                    exp.ring_address = slot[ADDR_W-1:0];
                end
            end
        end
        tally[exp.status]++;
        if (exp.compacted) compactions++;
        placements_due.push_back(exp);
    endfunction

    function void report_mismatch(string field, int unsigned want, int unsigned got);
        fails++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr,
                               logic comp);
        t_placement_result exp;
        if (placements_due.size() == 0) begin
            fails++;
            $error("result beat with nothing pending: status %0d address %0d", status, addr);
            return;
        end
        exp = placements_due.pop_front();
        if (status !== exp.status) report_mismatch("status", exp.status, status);
        if (addr !== exp.ring_address) report_mismatch("ring_address", exp.ring_address, addr);
        if (comp !== exp.compacted) report_mismatch("compacted", exp.compacted, comp);
    endfunction
endclass

module tb_resident_ring_placement_core;
    import rrp_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 325;
    localparam int CLEAR_CAP   = 24;    // clears walk the whole table, keep them rare

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [THR_W-1:0]    i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [TYPE_W-1:0]   i_req_type = REQ_PLACE;
    logic [INDEX_W-1:0]  i_entry_index = '0;
    logic [SPAN_W-1:0]   i_span = '0;
    logic [DRAW_W-1:0]   i_draw_items = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0]   o_ring_address;
    logic                o_compacted;

    placement_scoreboard sb = new();

    int         cycles = 0;
    int         beats_sent = 0;
    int         clears_sent = 0;
    int         rx_hold = 0;
    bit         rx_steady = 1'b0;      // receiver starts no new stalls while set
    bit         tx_steady = 1'b0;      // sender never idles while set
    bit [15:0]  cur_thr = THR_RESET;   // mirrors the threshold register for stimulus
    int         ws_base = 0;           // working set of entries, so frames see hits
    int         ws_size = 16;

    resident_ring_placement_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_entry_index  (i_entry_index),
        .i_span         (i_span),
        .i_draw_items   (i_draw_items),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_ring_address (o_ring_address),
        .o_compacted    (o_compacted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: sized for ~2k beats with worst-case gaps/stalls plus the reset and clear sweeps
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL resident_ring_placement_core");
            $finish;
        end
    end

    // Monitor: pre-edge values, so accepted beats are seen exactly as driven.
    // Request before result in case both land on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.take_request(i_req_type, i_entry_index, i_span, i_draw_items);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_ring_address, o_compacted);
    end

    function automatic int pick_rx_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Result side back-pressure: alternating ready/stall stretches of random length
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_steady) begin
            i_out_ready <= 1'b1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            rx_hold <= pick_rx_stall();
        end else begin
            i_out_ready <= 1'b1;
            rx_hold <= $urandom_range(0, 12);
        end
    end

    function automatic int pick_tx_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly small models, some large, a few malformed spans
    function automatic logic [SPAN_W-1:0] pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return '0;
        if (r < 4) return SPAN_W'($urandom_range(WINDOW_VERTICES + 1, 131071));
        if (r < 60) return SPAN_W'($urandom_range(1, 1024));
        if (r < 85) return SPAN_W'($urandom_range(1025, 16384));
        if (r < 96) return SPAN_W'($urandom_range(16385, WINDOW_VERTICES - 1));
        return SPAN_W'(WINDOW_VERTICES);
    endfunction

    // Half of the draw counts sit within one of the compaction threshold
    function automatic logic [DRAW_W-1:0] pick_draws();
        int d;
        if ($urandom_range(0, 1) == 0) return DRAW_W'($urandom);
        d = int'(cur_thr) + $urandom_range(0, 2) - 1;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return DRAW_W'(d);
    endfunction

    // One request beat; valid is held across back-to-back beats
    task automatic send_req(input logic [TYPE_W-1:0] req, input logic [INDEX_W-1:0] idx,
                            input logic [SPAN_W-1:0] span, input logic [DRAW_W-1:0] draws);
        int gap;
        gap = pick_tx_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_entry_index <= idx;
        i_span        <= span;
        i_draw_items  <= draws;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
        if (req == REQ_CLEAR) clears_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input bit [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_threshold(value);
        cur_thr = value;
        i_cfg_we <= 1'b0;
    endtask

    // Well-formed frame: start, places mostly from the working set, end
    task automatic run_frame();
        int n;
        int r;
        logic [INDEX_W-1:0] idx;
        // skipping the start now and then keeps an old guard serial alive
        if ($urandom_range(0, 99) < 80)
            send_req(REQ_FRAME_START, INDEX_W'($urandom), SPAN_W'($urandom), DRAW_W'($urandom));
        if ($urandom_range(0, 99) < 30) begin
            ws_size = $urandom_range(4, 32);
            ws_base = $urandom_range(0, TABLE_ENTRIES - ws_size);
        end
        n = $urandom_range(2, 24);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80) idx = INDEX_W'(ws_base + $urandom_range(0, ws_size - 1));
            else if (r < 96) idx = INDEX_W'($urandom_range(0, TABLE_ENTRIES - 1));
            else idx = INDEX_W'($urandom_range(TABLE_ENTRIES, 65535));
            send_req(REQ_PLACE, idx, pick_span(), pick_draws());
        end
        send_req(REQ_FRAME_END, INDEX_W'($urandom), SPAN_W'($urandom), pick_draws());
    endtask

    // Raw noise: every field random, with most clears turned into places
    task automatic run_noise();
        logic [TYPE_W-1:0] req;
        int n;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            req = TYPE_W'($urandom);
            if (req == REQ_CLEAR && ($urandom_range(0, 3) != 0 || clears_sent >= CLEAR_CAP))
                req = REQ_PLACE;
            send_req(req, INDEX_W'($urandom), SPAN_W'($urandom), DRAW_W'($urandom));
        end
    endtask

    initial begin
        bit [15:0] thr_plan [PHASES];
        int        phase_start;
        bit        drained_mid;

        thr_plan[0] = THR_RESET;           // reset value, not written
        thr_plan[1] = 16'd0;
        thr_plan[2] = 16'hFFFF;
        thr_plan[3] = 16'($urandom_range(1, 400));
        thr_plan[4] = 16'd1;
        thr_plan[5] = 16'($urandom);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: threshold at its reset value of 64
        send_req(REQ_PLACE, 16'd0, 17'd1, 16'd0);           // first placement, slot 0
        send_req(REQ_PLACE, 16'd0, 17'd1, 16'd0);           // resident hit
        send_req(REQ_PLACE, 16'd4095, 17'd65536, 16'd0);    // last entry, widest span
        send_req(REQ_PLACE, 16'd4096, 17'd1, 16'd0);        // index one past the table
        send_req(REQ_PLACE, 16'hFFFF, 17'd1, 16'd0);        // largest index
        send_req(REQ_PLACE, 16'd5, 17'd0, 16'd0);           // zero span
        send_req(REQ_PLACE, 16'd5, 17'd65537, 16'd0);       // span one past the window
        send_req(REQ_PLACE, 16'd5, 17'h1FFFF, 16'hFFFF);    // largest span
        send_req(REQ_PLACE, 16'd2, 17'd65536, 16'd0);       // lap change blocked by guard
        send_req(REQ_FRAME_START, 16'hFFFF, 17'h1FFFF, 16'hFFFF);
        send_req(REQ_PLACE, 16'd2, 17'd65536, 16'd65);      // new lap with compaction
        send_req(REQ_PLACE, 16'd0, 17'd1, 16'd0);           // stale entry, placed again
        send_req(REQ_FRAME_END, 16'd0, 17'd0, 16'd64);      // at threshold: no compaction
        send_req(REQ_FRAME_END, 16'd0, 17'd0, 16'd65);      // just above
        send_req(REQ_FRAME_END, 16'd0, 17'd0, 16'hFFFF);
        send_req(REQ_PLACE, 16'd2, 17'd1, 16'd0);           // guard hit after laps moved
        send_req(REQ_FRAME_START, 16'd0, 17'd0, 16'd0);
        send_req(REQ_PLACE, 16'd2, 17'd1, 16'd0);
        send_req(REQ_PLACE, 16'd2, 17'd1, 16'd0);           // hit
        send_req(REQ_CLEAR, 16'hFFFF, 17'h1FFFF, 16'hFFFF);
        send_req(REQ_PLACE, 16'd2, 17'd1, 16'd0);           // miss after clear
        send_req(REQ_PLACE, 16'd4095, 17'd65536, 16'd0);
        send_req(REQ_FRAME_START, 16'h5A5A, 17'h0A5A5, 16'hA5A5);
        send_req(REQ_FRAME_END, 16'hA5A5, 17'h15A5A, 16'd0);

        // Random phases, one threshold setting each
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                repeat (8) @(posedge i_clk);
                write_threshold(thr_plan[p]);
            end
            phase_start = beats_sent;
            drained_mid = 1'b0;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 12) tx_steady = !tx_steady;
                if ($urandom_range(0, 99) < 10) rx_steady <= !rx_steady;
                // hold off once per phase until every result is back
                if (!drained_mid && beats_sent - phase_start >= PHASE_BEATS / 2) begin
                    drained_mid = 1'b1;
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 85) run_frame();
                else run_noise();
                if (clears_sent < CLEAR_CAP && $urandom_range(0, 99) < 2)
                    send_req(REQ_CLEAR, INDEX_W'($urandom), SPAN_W'($urandom),
                             DRAW_W'($urandom));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Run: %0d request beats in %0d cycles, %0d threshold settings, %0d clears",
                 beats_sent, cycles, PHASES, clears_sent);
        $display("Run: hits %0d, placed %0d, new lap %0d, rejected %0d, events %0d,",
                 sb.tally[ST_HIT], sb.tally[ST_PLACED], sb.tally[ST_NEWLAP],
                 sb.tally[ST_REJECT], sb.tally[ST_EVENT]);
        $display("     compactions %0d", sb.compactions);
        if (sb.fails == 0 && sb.outstanding() == 0) begin
            $display("PASS resident_ring_placement_core");
        end else begin
            $display("FAIL resident_ring_placement_core");
        end
        $finish;
    end

endmodule
